// ----- rtl/arp_pkg.sv -----
// Package for the audio ring producer: widths, commands, item and result types.
`timescale 1ns / 1ps

package arp_pkg;

    // Ring store geometry
    localparam int DEPTH   = 8192;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int SIZE_W  = ADDR_W + 1;

    // Stream widths
    localparam int IN_TDATA_W  = 32;
    localparam int IN_USED_W   = 25;
    localparam int OUT_TDATA_W = 32;
    localparam int CMD_W       = 2;
    localparam int POS_W       = 16;
    localparam int FREE_W      = 13;
    localparam int COUNT_W     = 14;

    // Front-to-back queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE = 2'd0,
        CMD_QUERY = 2'd1,
        CMD_FILL  = 2'd2,
        CMD_RESET = 2'd3
    } t_cmd;

    // Classified item as it travels through the queue
    typedef struct packed {
        t_cmd              cmd;
        logic [7:0]        data_byte;
        logic              burst_last;
        logic              pos_ok;
        logic [ADDR_W-1:0] pos;
    } t_item;

    // One result beat, accepted in the lowest bit
    typedef struct packed {
        logic               is_armed;
        logic               arm_start;
        logic [COUNT_W-1:0] burst_count;
        logic [FREE_W-1:0]  free_bytes;
        logic               accepted;
    } t_result;

    localparam int RESULT_W = $bits(t_result);

    typedef enum logic [1:0] {
        ST_RUN   = 2'd0,
        ST_FILL  = 2'd1,
        ST_RED_W = 2'd2,
        ST_RED_C = 2'd3
    } t_back_state;

endpackage

// ----- rtl/audio_ring_producer.sv -----
// Top level of the audio ring producer: config register, front, queue and back.
//
//  channel   dir  handshake              contents
//  s_axis    in   tvalid/tready          tdata, tlast = burst_last, tuser = cmd
//  m_axis    out  tvalid/tready          tdata = one result beat
//  cfg       in   i_cfg_we               i_cfg_wdata = ring_size
//
// A write or query beat executes as it is popped; its result passes through
// the queue and the output register, and the steady rate is one beat per cycle
// while the back end runs and the sink keeps up. A fill holds the back end and
// writes one store byte per cycle up to S (S = ring size in use). A ring_size
// write starts a pointer reduction in the remainder unit; the queue takes up to
// two beats meanwhile. Reset is synchronous; the store is not cleared. Either side
// may stall: the two-entry queue and the output register decouple them.
`timescale 1ns / 1ps

module audio_ring_producer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [13:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] data_byte, [8] play_valid, [24:9] play_pos, [31:25] zero
    input  logic [31:0] s_axis_tdata,
    input  logic        s_axis_tlast,
    // [1:0] cmd
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] accepted, [13:1] free_bytes, [27:14] burst_count, [28] arm_start,
    // [29] is_armed, [31:30] zero
    output logic [31:0] m_axis_tdata
);
    import arp_pkg::*;

    logic [SIZE_W-1:0] r_ring_size;
    logic [SIZE_W-1:0] size_use;
    logic              f_valid;
    t_item             f_item;
    logic              q_ready;
    logic              q_valid;
    t_item             q_item;
    logic              q_pop;
    t_result           result;

    // Ring size register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_size <= '0;
        end else if (i_cfg_we) begin
            r_ring_size <= i_cfg_wdata;
        end
    end

    // Zero selects the full depth; oversize clamps to it
    always_comb begin
        if (r_ring_size == '0 || r_ring_size > SIZE_W'(DEPTH)) begin
            size_use = SIZE_W'(DEPTH);
        end else begin
            size_use = r_ring_size;
        end
    end

    arp_front u_front (
        .i_tvalid     (s_axis_tvalid),
        .o_tready     (s_axis_tready),
        .i_tdata      (s_axis_tdata[IN_USED_W-1:0]),
        .i_tlast      (s_axis_tlast),
        .i_tuser      (s_axis_tuser),
        .i_size       (size_use),
        .o_item_valid (f_valid),
        .o_item       (f_item),
        .i_item_ready (q_ready)
    );

    arp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_item  (f_item),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_pop   (q_pop)
    );

    arp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_size       (size_use),
        .i_cfg_we     (i_cfg_we),
        .i_item_valid (q_valid),
        .i_item       (q_item),
        .o_item_pop   (q_pop),
        .o_valid      (m_axis_tvalid),
        .o_result     (result),
        .i_ready      (m_axis_tready)
    );

    assign m_axis_tdata = {(OUT_TDATA_W - RESULT_W)'(0), result};

endmodule

// ----- rtl/arp_front.sv -----
// Front end: accepts input beats and classifies them into queue items.
`timescale 1ns / 1ps

module arp_front (
    input  logic                         i_tvalid,
    output logic                         o_tready,
    input  logic [arp_pkg::IN_USED_W-1:0] i_tdata,
    input  logic                         i_tlast,
    input  logic [arp_pkg::CMD_W-1:0]    i_tuser,
    input  logic [arp_pkg::SIZE_W-1:0]   i_size,
    output logic                         o_item_valid,
    output arp_pkg::t_item               o_item,
    input  logic                         i_item_ready
);
    import arp_pkg::*;

    logic [POS_W-1:0] play_pos;
    logic             play_valid;

    assign play_valid = i_tdata[8];
    assign play_pos   = i_tdata[24:9];

    // Cursor is usable only when present and inside the ring in use
    always_comb begin
        o_item.cmd        = t_cmd'(i_tuser);
        o_item.data_byte  = i_tdata[7:0];
        o_item.burst_last = i_tlast;
        o_item.pos_ok     = play_valid && (play_pos < POS_W'(i_size));
        o_item.pos        = play_pos[ADDR_W-1:0];
    end

    assign o_item_valid = i_tvalid;
    assign o_tready     = i_item_ready;

endmodule

// ----- rtl/arp_queue.sv -----
// Short queue of classified items between front and back.
`timescale 1ns / 1ps

module arp_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  arp_pkg::t_item i_item,
    output logic           o_ready,
    output logic           o_valid,
    output arp_pkg::t_item o_item,
    input  logic           i_pop
);
    import arp_pkg::*;

    t_item             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push;
    logic              do_pop;

    assign o_ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) r_wptr <= r_wptr + 1'b1;
            if (do_pop)  r_rptr <= r_rptr + 1'b1;
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wptr] <= i_item;
    end

endmodule

// ----- rtl/arp_mod.sv -----
// Iterative remainder unit: one quotient bit per cycle.
`timescale 1ns / 1ps

module arp_mod (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [arp_pkg::ADDR_W-1:0] i_dividend,
    input  logic [arp_pkg::SIZE_W-1:0] i_divisor,
    output logic                       o_done,
    output logic [arp_pkg::ADDR_W-1:0] o_rem
);
    import arp_pkg::*;

    localparam int STEP_W = $clog2(ADDR_W);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [ADDR_W-1:0] r_rem;
    logic [ADDR_W-1:0] r_dvd;
    logic [SIZE_W-1:0] shifted;
    logic [SIZE_W-1:0] diff;
    logic [ADDR_W-1:0] n_rem;

    // Shift in the next dividend bit, subtract if it fits
    always_comb begin
        shifted = {r_rem, r_dvd[ADDR_W-1]};
        diff    = shifted - i_divisor;
        n_rem   = (shifted >= i_divisor) ? diff[ADDR_W-1:0] : shifted[ADDR_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(ADDR_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvd <= i_dividend;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[ADDR_W-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ----- rtl/arp_back.sv -----
// Back end: executes queued items against the ring store and pointers.
`timescale 1ns / 1ps

module arp_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [arp_pkg::SIZE_W-1:0] i_size,
    input  logic                       i_cfg_we,
    input  logic                       i_item_valid,
    input  arp_pkg::t_item             i_item,
    output logic                       o_item_pop,
    output logic                       o_valid,
    output arp_pkg::t_result           o_result,
    input  logic                       i_ready
);
    import arp_pkg::*;

    // Ring store, write only
    logic [7:0] r_store [DEPTH];

    t_back_state        r_state,    n_state;
    logic [ADDR_W-1:0]  r_wr_raw,   n_wr_raw;
    logic [ADDR_W-1:0]  r_wr_mod,   n_wr_mod;
    logic [ADDR_W-1:0]  r_cur_raw,  n_cur_raw;
    logic [ADDR_W-1:0]  r_cur_mod,  n_cur_mod;
    logic               r_armed,    n_armed;
    logic [FREE_W-1:0]  r_budget,   n_budget;
    logic               r_open,     n_open;
    logic [COUNT_W-1:0] r_cnt,      n_cnt;
    logic [ADDR_W-1:0]  r_fill_idx, n_fill_idx;
    logic [7:0]         r_fill_byte, n_fill_byte;
    logic               r_mod_start, n_mod_start;
    logic               r_out_valid, n_out_valid;
    t_result            r_out,      n_out;

    logic               mem_we;
    logic [ADDR_W-1:0]  mem_addr;
    logic [7:0]         mem_wdata;

    logic               pop;
    logic               tiny;
    logic [ADDR_W-1:0]  play;
    logic [SIZE_W:0]    span;
    logic [SIZE_W:0]    span_wrap;
    logic [FREE_W-1:0]  free_calc;
    logic               cursor_upd;
    logic [SIZE_W-1:0]  wp1;
    logic [ADDR_W-1:0]  w_next;
    logic [FREE_W-1:0]  budget;
    logic [COUNT_W-1:0] cnt;
    logic               mod_done;
    logic [ADDR_W-1:0]  mod_rem;
    logic [ADDR_W-1:0]  mod_dividend;
    t_result            res;

    // Pointer reduction after a ring size change
    assign mod_dividend = (r_state == ST_RED_C) ? r_cur_raw : r_wr_raw;

    arp_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_mod_start),
        .i_dividend (mod_dividend),
        .i_divisor  (i_size),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    // Free space from the reduced pointers
    always_comb begin
        tiny       = (i_size < SIZE_W'(2));
        play       = i_item.pos_ok ? i_item.pos : r_cur_mod;
        span       = (SIZE_W+1)'(play) + (SIZE_W+1)'(i_size)
                   - (SIZE_W+1)'(r_wr_mod) - (SIZE_W+1)'(1);
        span_wrap  = (span >= (SIZE_W+1)'(i_size)) ? span - (SIZE_W+1)'(i_size) : span;
        if (tiny) begin
            free_calc = '0;
        end else if (!r_armed) begin
            free_calc = FREE_W'(i_size - SIZE_W'(1));
        end else begin
            free_calc = span_wrap[FREE_W-1:0];
        end
        cursor_upd = !tiny && r_armed && i_item.pos_ok;
        wp1        = SIZE_W'(r_wr_mod) + SIZE_W'(1);
        w_next     = (wp1 >= i_size) ? '0 : wp1[ADDR_W-1:0];
    end

    // Next state, execution and store port
    always_comb begin
        n_state     = r_state;
        n_wr_raw    = r_wr_raw;
        n_wr_mod    = r_wr_mod;
        n_cur_raw   = r_cur_raw;
        n_cur_mod   = r_cur_mod;
        n_armed     = r_armed;
        n_budget    = r_budget;
        n_open      = r_open;
        n_cnt       = r_cnt;
        n_fill_idx  = r_fill_idx;
        n_fill_byte = r_fill_byte;
        n_mod_start = 1'b0;
        n_out_valid = r_out_valid && !i_ready;
        n_out       = r_out;
        mem_we      = 1'b0;
        mem_addr    = r_wr_mod;
        mem_wdata   = i_item.data_byte;
        budget      = r_budget;
        cnt         = r_cnt;
        res         = '0;

        pop = (r_state == ST_RUN) && i_item_valid && (!r_out_valid || i_ready);

        case (r_state)
            ST_RUN: begin
                if (pop) begin
                    case (i_item.cmd)
                        CMD_WRITE: begin
                            // First beat of a burst takes the budget
                            if (!r_open) begin
                                budget = free_calc;
                                cnt    = '0;
                                if (cursor_upd) begin
                                    n_cur_raw = i_item.pos;
                                    n_cur_mod = i_item.pos;
                                end
                            end
                            n_budget = budget;
                            n_cnt    = cnt;
                            if (cnt < COUNT_W'(budget)) begin
                                mem_we       = 1'b1;
                                n_wr_raw     = w_next;
                                n_wr_mod     = w_next;
                                res.accepted = 1'b1;
                                if (cnt < COUNT_W'(DEPTH)) n_cnt = cnt + 1'b1;
                                if (!r_armed) begin
                                    n_cur_raw     = '0;
                                    n_cur_mod     = '0;
                                    n_armed       = 1'b1;
                                    res.arm_start = 1'b1;
                                end
                            end
                            res.free_bytes = budget;
                            n_open         = !i_item.burst_last;
                        end
                        CMD_QUERY: begin
                            res.free_bytes = free_calc;
                            if (cursor_upd) begin
                                n_cur_raw = i_item.pos;
                                n_cur_mod = i_item.pos;
                            end
                        end
                        CMD_FILL: begin
                            n_state     = ST_FILL;
                            n_fill_idx  = '0;
                            n_fill_byte = i_item.data_byte;
                        end
                        CMD_RESET: begin
                            n_wr_raw  = '0;
                            n_wr_mod  = '0;
                            n_cur_raw = '0;
                            n_cur_mod = '0;
                            n_armed   = 1'b0;
                            n_open    = 1'b0;
                            n_budget  = '0;
                            n_cnt     = '0;
                        end
                        default: begin
                        end
                    endcase
                    res.burst_count = n_cnt;
                    res.is_armed    = n_armed;
                    n_out           = res;
                    n_out_valid     = 1'b1;
                end
            end
            ST_FILL: begin
                // One store entry per cycle up to the ring size
                mem_we    = 1'b1;
                mem_addr  = r_fill_idx;
                mem_wdata = r_fill_byte;
                if (SIZE_W'(r_fill_idx) == i_size - SIZE_W'(1)) begin
                    n_state = ST_RUN;
                end else begin
                    n_fill_idx = r_fill_idx + 1'b1;
                end
            end
            ST_RED_W: begin
                if (mod_done) begin
                    n_wr_mod    = mod_rem;
                    n_state     = ST_RED_C;
                    n_mod_start = 1'b1;
                end
            end
            ST_RED_C: begin
                if (mod_done) begin
                    n_cur_mod = mod_rem;
                    n_state   = ST_RUN;
                end
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase

        // A new ring size restarts pointer reduction
        if (i_cfg_we) begin
            n_state     = ST_RED_W;
            n_mod_start = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RUN;
            r_wr_raw    <= '0;
            r_wr_mod    <= '0;
            r_cur_raw   <= '0;
            r_cur_mod   <= '0;
            r_armed     <= 1'b0;
            r_budget    <= '0;
            r_open      <= 1'b0;
            r_cnt       <= '0;
            r_mod_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wr_raw    <= n_wr_raw;
            r_wr_mod    <= n_wr_mod;
            r_cur_raw   <= n_cur_raw;
            r_cur_mod   <= n_cur_mod;
            r_armed     <= n_armed;
            r_budget    <= n_budget;
            r_open      <= n_open;
            r_cnt       <= n_cnt;
            r_mod_start <= n_mod_start;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_fill_idx  <= n_fill_idx;
        r_fill_byte <= n_fill_byte;
        r_out       <= n_out;
    end

    // Store write port
    always_ff @(posedge i_clk) begin
        if (mem_we) r_store[mem_addr] <= mem_wdata;
    end

    assign o_item_pop = pop;
    assign o_valid    = r_out_valid;
    assign o_result   = r_out;

endmodule

// ----- verif/tb_audio_ring_producer.sv -----
// Self-checking testbench for the audio ring producer: directed table, then random phases.
`timescale 1ns / 1ps

module tb_audio_ring_producer;

    import arp_pkg::*;

    localparam int LONG_HOLD   = 300;
    localparam int PHASE_ITEMS = 120;
    localparam int NUM_PHASES  = 13;

    // One row of the directed table; pinned rows carry a hand-written result
    typedef struct packed {
        t_cmd        cmd;
        logic [7:0]  data;
        logic        last;
        logic        pv;
        logic [15:0] pos;
        logic        pinned;
        t_result     want;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [13:0] i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // [7:0] data_byte, [8] play_valid, [24:9] play_pos, [31:25] zero
    logic [31:0] s_axis_tdata;
    logic        s_axis_tlast;
    // [1:0] cmd
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // [0] accepted, [13:1] free_bytes, [27:14] burst_count, [28] arm_start,
    // [29] is_armed, [31:30] zero
    logic [31:0] m_axis_tdata;

    // Pinned expectation travels with the beat it belongs to
    logic        pin_valid;
    t_result     pin_result;

    // Predictor state of the ring
    logic [ADDR_W-1:0]  wr_pos;
    logic [ADDR_W-1:0]  play_cursor;
    logic               armed_q;
    logic [FREE_W-1:0]  budget_q;
    logic               burst_on;
    logic [COUNT_W-1:0] burst_taken;
    logic [13:0]        ring_size_q;

    t_result pending_results[$];
    t_result predicted;
    t_result observed;
    t_result oldest;
    int      err_count;

    // Pacing controls for the stimulus and the sink
    bit src_eager;
    bit src_forced;
    bit sink_eager;
    bit hold_sink_req;
    int sent_total;

    audio_ring_producer DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog
    initial begin
        #(30_000_000);
        $display("DONE: errors detected");
        $finish;
    end

    // Ring size in use: 0 and anything above DEPTH select DEPTH
    function automatic int unsigned size_in_use(logic [13:0] v);
        int unsigned s;
        s = (v == 0) ? DEPTH : v;
        if (s > DEPTH) s = DEPTH;
        return s;
    endfunction

    // Free space; when armed and S >= 2, a valid in-range cursor also refreshes the kept cursor
    function automatic int unsigned free_space(int unsigned s, logic pv, logic [15:0] pos);
        int unsigned play;
        int unsigned w;
        if (s < 2) return 0;
        if (!armed_q) return s - 1;
        if (pv && pos < s) begin
            play_cursor = pos[ADDR_W-1:0];
            play = pos;
        end else begin
            play = play_cursor % s;
        end
        w = wr_pos % s;
        return (play + s - w - 1) % s;
    endfunction

    // Expected result of one beat; the store contents are never visible, so not kept
    function automatic t_result ring_predict(t_cmd c, logic last, logic pv, logic [15:0] pos);
        t_result r;
        int unsigned s;
        int unsigned w;
        r = '0;
        s = size_in_use(ring_size_q);
        case (c)
            CMD_WRITE: begin
                if (!burst_on) begin
                    budget_q = FREE_W'(free_space(s, pv, pos));
                    burst_on = 1'b1;
                    burst_taken = '0;
                end
                if (burst_taken < budget_q) begin
                    w = (wr_pos % s) + 1;
                    wr_pos = (w >= s) ? '0 : w[ADDR_W-1:0];
                    r.accepted = 1'b1;
                    if (burst_taken < DEPTH) burst_taken = burst_taken + 1'b1;
                    if (!armed_q) begin
                        play_cursor = '0;
                        armed_q = 1'b1;
                        r.arm_start = 1'b1;
                    end
                end
                r.free_bytes = budget_q;
                if (last) burst_on = 1'b0;
            end
            CMD_QUERY: begin
                r.free_bytes = FREE_W'(free_space(s, pv, pos));
            end
            CMD_FILL: begin
            end
            default: begin
                wr_pos = '0;
                play_cursor = '0;
                armed_q = 1'b0;
                burst_on = 1'b0;
                budget_q = '0;
                burst_taken = '0;
            end
        endcase
        r.burst_count = burst_taken;
        r.is_armed = armed_q;
        return r;
    endfunction

    task automatic note_error(input string msg);
        begin
            if (err_count < 10) $display("%s", msg);
            err_count++;
        end
    endtask

    // Rising edge: predict accepted input beats, check accepted output beats
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            wr_pos <= '0;
            play_cursor <= '0;
            armed_q <= 1'b0;
            budget_q <= '0;
            burst_on <= 1'b0;
            burst_taken <= '0;
            ring_size_q <= '0;
        end else begin
            if (i_cfg_we) ring_size_q = i_cfg_wdata;
            if (s_axis_tvalid && s_axis_tready === 1'b1) begin
                predicted = ring_predict(t_cmd'(s_axis_tuser), s_axis_tlast,
                                         s_axis_tdata[8], s_axis_tdata[24:9]);
                pending_results.push_back(pin_valid ? pin_result : predicted);
            end
            if (m_axis_tvalid === 1'b1 && m_axis_tready) begin
                observed = t_result'(m_axis_tdata[RESULT_W-1:0]);
                if (pending_results.size() == 0) begin
                    note_error($sformatf("unexpected beat: acc=%0d free=%0d cnt=%0d arm=%0d armed=%0d",
                        observed.accepted, observed.free_bytes, observed.burst_count,
                        observed.arm_start, observed.is_armed));
                end else begin
                    oldest = pending_results.pop_front();
                    if (observed.accepted !== oldest.accepted ||
                        observed.free_bytes !== oldest.free_bytes ||
                        observed.burst_count !== oldest.burst_count ||
                        observed.arm_start !== oldest.arm_start ||
                        observed.is_armed !== oldest.is_armed) begin
                        note_error($sformatf({"mismatch: exp acc=%0d free=%0d cnt=%0d arm=%0d ",
                            "armed=%0d, got acc=%0d free=%0d cnt=%0d arm=%0d armed=%0d"},
                            oldest.accepted, oldest.free_bytes, oldest.burst_count,
                            oldest.arm_start, oldest.is_armed,
                            observed.accepted, observed.free_bytes, observed.burst_count,
                            observed.arm_start, observed.is_armed));
                    end
                end
            end
        end
    end

    // Sink: random stall per beat, eager stretches, one long hold on request
    initial begin : sink_proc
        int stall;
        int beats;
        m_axis_tready = 1'b0;
        sink_eager = 1'b0;
        beats = 0;
        forever begin
            if (hold_sink_req) begin
                @(negedge i_clk);
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge i_clk);
                hold_sink_req = 1'b0;
            end
            if (beats % 40 == 0) sink_eager = ($urandom_range(0, 3) == 0);
            stall = sink_eager ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
                @(negedge i_clk);
                m_axis_tready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (m_axis_tvalid !== 1'b1) @(posedge i_clk);
            beats++;
        end
    end

    // Offer one beat after a random gap and hold it until taken
    task automatic send_item(input t_cmd c, input logic [7:0] d, input logic l, input logic v,
                             input logic [15:0] p, input logic pin, input t_result want);
        int gap;
        begin
            if (sent_total % 40 == 0 && !src_forced) src_eager = ($urandom_range(0, 3) == 0);
            sent_total++;
            gap = src_eager ? 0 : $urandom_range(0, 8);
            if (gap > 0) begin
                @(negedge i_clk);
                s_axis_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            s_axis_tvalid <= 1'b1;
            s_axis_tuser  <= c;
            s_axis_tlast  <= l;
            s_axis_tdata  <= {7'd0, p, v, d};
            pin_valid     <= pin;
            pin_result    <= want;
            @(posedge i_clk);
            while (s_axis_tready !== 1'b1) @(posedge i_clk);
        end
    endtask

    // Random content for one beat of the given kind
    task automatic send_random(input t_cmd c, input logic l, input int unsigned s);
        logic [15:0] p;
        begin
            case ($urandom_range(0, 9))
                0: p = 16'($urandom_range(0, 65535));
                1: p = 16'(s);
                2: p = 16'(s - 1);
                default: p = 16'($urandom_range(0, s - 1));
            endcase
            send_item(c, 8'($urandom_range(0, 255)), l, ($urandom_range(0, 4) != 0), p,
                      1'b0, '0);
        end
    endtask

    // Stop offering and wait until every expected beat has come back
    task automatic drain_results;
        begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            while (pending_results.size() != 0) @(negedge i_clk);
        end
    endtask

    // Register write while idle; the wait covers a trailing fill of the whole store
    task automatic set_ring_size(input logic [13:0] v);
        begin
            drain_results();
            repeat (DEPTH + 64) @(negedge i_clk);
            i_cfg_we    <= 1'b1;
            i_cfg_wdata <= v;
            @(negedge i_clk);
            i_cfg_we    <= 1'b0;
        end
    endtask

    function automatic t_row row(input t_cmd c, input logic [7:0] d, input logic l,
                                 input logic v, input logic [15:0] p, input logic pin,
                                 input logic acc, input logic [12:0] fr, input logic [13:0] cnt,
                                 input logic arm, input logic armd);
        t_row r;
        r.cmd = c;
        r.data = d;
        r.last = l;
        r.pv = v;
        r.pos = p;
        r.pinned = pin;
        r.want.accepted = acc;
        r.want.free_bytes = fr;
        r.want.burst_count = cnt;
        r.want.arm_start = arm;
        r.want.is_armed = armd;
        return r;
    endfunction

    function automatic logic [13:0] phase_ring_size(input int p);
        case (p)
            0:  return 14'd17;
            1:  return 14'd16383;
            2:  return 14'd1;
            3:  return 14'd0;
            4:  return 14'd2;
            5:  return 14'd3;
            6:  return 14'd8191;
            7:  return 14'd64;
            8:  return 14'd9000;
            9:  return 14'd5;
            10: return 14'd8192;
            11: return 14'd300;
            default: return 14'd4;
        endcase
    endfunction

    // Random traffic: mostly bursts of writes, with queries, resets and fills mixed in
    task automatic run_phase(input int unsigned s, input int n, input int phase);
        int count;
        int len;
        int max_len;
        int k;
        int pick;
        logic broken;
        logic held;
        logic drained;
        begin
            count = 0;
            held = 1'b0;
            drained = 1'b0;
            while (count < n) begin
                if (phase == 7 && count >= 20 && !held) begin
                    // block fills up behind a long sink hold
                    held = 1'b1;
                    hold_sink_req = 1'b1;
                    src_forced = 1'b1;
                    src_eager = 1'b1;
                    repeat (24) send_random(CMD_WRITE, ($urandom_range(0, 3) == 0), s);
                    count += 24;
                    src_forced = 1'b0;
                end
                if (phase == 9 && count >= 60 && !drained) begin
                    drained = 1'b1;
                    drain_results();
                end
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    max_len = (s <= 64) ? s + 4 : 16;
                    if ($urandom_range(0, 9) == 0) max_len = 48;
                    len = $urandom_range(1, max_len);
                    broken = ($urandom_range(0, 9) == 0);
                    for (k = 0; k < len; k++) begin
                        if ($urandom_range(0, 19) == 0) begin
                            send_random(CMD_QUERY, 1'($urandom_range(0, 1)), s);
                            count++;
                        end
                        send_random(CMD_WRITE, (k == len - 1) && !broken, s);
                        count++;
                    end
                end else if (pick < 84) begin
                    send_random(CMD_QUERY, 1'($urandom_range(0, 1)), s);
                    count++;
                end else if (pick < 90 || (s > 512 && $urandom_range(0, 3) != 0)) begin
                    send_random(CMD_RESET, 1'($urandom_range(0, 1)), s);
                    count++;
                end else begin
                    send_random(CMD_FILL, 1'($urandom_range(0, 1)), s);
                    count++;
                end
            end
        end
    endtask

    // Main sequence
    initial begin : stimulus
        t_row rows[$];
        int i;
        int p;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        s_axis_tuser  = CMD_WRITE;
        pin_valid     = 1'b0;
        pin_result    = '0;
        err_count     = 0;
        sent_total    = 0;
        src_eager     = 1'b0;
        src_forced    = 1'b0;
        hold_sink_req = 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table at the reset ring size (full depth)
        rows.push_back(row(CMD_QUERY, 8'h00, 0, 0, 16'd0,     1, 0, 13'd8191, 14'd0, 0, 0));
        rows.push_back(row(CMD_QUERY, 8'h00, 0, 1, 16'hFFFF,  1, 0, 13'd8191, 14'd0, 0, 0));
        rows.push_back(row(CMD_WRITE, 8'hFF, 1, 0, 16'd0,     1, 1, 13'd8191, 14'd1, 1, 1));
        rows.push_back(row(CMD_QUERY, 8'h00, 0, 0, 16'd0,     1, 0, 13'd8190, 14'd1, 0, 1));
        rows.push_back(row(CMD_QUERY, 8'h00, 1, 1, 16'd8191,  0, 0, 0, 0, 0, 0));
        rows.push_back(row(CMD_QUERY, 8'h00, 0, 1, 16'd8192,  0, 0, 0, 0, 0, 0));
        rows.push_back(row(CMD_WRITE, 8'h00, 0, 1, 16'd1,     0, 0, 0, 0, 0, 0));
        rows.push_back(row(CMD_WRITE, 8'h5A, 0, 0, 16'd0,     0, 0, 0, 0, 0, 0));
        rows.push_back(row(CMD_QUERY, 8'h00, 0, 1, 16'd100,   0, 0, 0, 0, 0, 0));
        rows.push_back(row(CMD_WRITE, 8'hC3, 1, 1, 16'd7,     0, 0, 0, 0, 0, 0));
        rows.push_back(row(CMD_FILL,  8'hA5, 0, 1, 16'd5,     0, 0, 0, 0, 0, 0));
        rows.push_back(row(CMD_RESET, 8'h00, 1, 0, 16'd0,     1, 0, 13'd0,    14'd0, 0, 0));
        rows.push_back(row(CMD_QUERY, 8'h00, 0, 1, 16'd3,     1, 0, 13'd8191, 14'd0, 0, 0));
        rows.push_back(row(CMD_WRITE, 8'h81, 1, 1, 16'hFFFF,  1, 1, 13'd8191, 14'd1, 1, 1));
        // cursor right ahead of the write position: ring full, byte refused
        rows.push_back(row(CMD_WRITE, 8'h7E, 1, 1, 16'd2,     1, 0, 13'd0,    14'd0, 0, 1));
        rows.push_back(row(CMD_WRITE, 8'h11, 1, 1, 16'd0,     0, 0, 0, 0, 0, 0));
        rows.push_back(row(CMD_FILL,  8'h00, 1, 0, 16'd0,     0, 0, 0, 0, 0, 0));
        rows.push_back(row(CMD_RESET, 8'hFF, 0, 1, 16'hFFFF,  1, 0, 13'd0,    14'd0, 0, 0));
        for (i = 0; i < rows.size(); i++) begin
            send_item(rows[i].cmd, rows[i].data, rows[i].last, rows[i].pv, rows[i].pos,
                      rows[i].pinned, rows[i].want);
        end

        // Random phases, each at its own ring size
        for (p = 0; p < NUM_PHASES; p++) begin
            set_ring_size(phase_ring_size(p));
            run_phase(size_in_use(phase_ring_size(p)), PHASE_ITEMS, p);
        end

        drain_results();
        repeat (64) @(negedge i_clk);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/arp_pkg.sv
rtl/arp_front.sv
rtl/arp_queue.sv
rtl/arp_mod.sv
rtl/arp_back.sv
rtl/audio_ring_producer.sv
verif/tb_audio_ring_producer.sv
